// File: rtl/core/lkw_pkg.sv
// Shared types and constants for the Lanczos-2 kernel weight generator.
// No dependencies; every other file but lkw_if.sv imports this package.
package lkw_pkg;

    localparam int TAP_SLOTS = 15;
    localparam int TERMS     = 9;
    localparam logic [31:0] ONE_Q28 = 32'h1000_0000;
    localparam logic [31:0] PI2_Q28 = 32'd2649351758;
    localparam logic [17:0] CENTER_RAW = 18'h1_0000;
    localparam logic [32:0] TWO_P32 = 33'h1_0000_0000;

    // job handed from front to back
    typedef struct packed {
        logic [15:0] ratio;
        logic [3:0]  taps;
    } t_job;

    typedef struct packed {
        logic        start;
        logic [39:0] dividend;
        logic [23:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [39:0] quotient;
    } t_div_rsp;

    typedef enum logic [3:0] {
        B_IDLE, B_TAP, B_TDIV, B_SQ, B_U, B_HMUL, B_HSTART, B_HWAIT, B_HFIX,
        B_L1, B_L2, B_L3, B_NEXT, B_NSTART, B_NWAIT, B_NPUT
    } t_back_state;

    // Horner divisors, sine series then cosine series
    function automatic logic [8:0] horner_div(input logic [3:0] k, input logic is_cos);
        logic [8:0] k2;
        k2 = {4'd0, k, 1'b0};
        return is_cos ? 9'((k2 - 9'd1) * k2) : 9'(k2 * (k2 + 9'd1));
    endfunction

    // floor(2^32 / Horner divisor); estimate is low by at most one for dividends below 2^32
    function automatic logic [31:0] horner_recip(input logic [3:0] k, input logic is_cos);
        logic [31:0] m;
        unique case (k)
            4'd1:    m = is_cos ? 32'(TWO_P32 / 33'd2)   : 32'(TWO_P32 / 33'd6);
            4'd2:    m = is_cos ? 32'(TWO_P32 / 33'd12)  : 32'(TWO_P32 / 33'd20);
            4'd3:    m = is_cos ? 32'(TWO_P32 / 33'd30)  : 32'(TWO_P32 / 33'd42);
            4'd4:    m = is_cos ? 32'(TWO_P32 / 33'd56)  : 32'(TWO_P32 / 33'd72);
            4'd5:    m = is_cos ? 32'(TWO_P32 / 33'd90)  : 32'(TWO_P32 / 33'd110);
            4'd6:    m = is_cos ? 32'(TWO_P32 / 33'd132) : 32'(TWO_P32 / 33'd156);
            4'd7:    m = is_cos ? 32'(TWO_P32 / 33'd182) : 32'(TWO_P32 / 33'd210);
            4'd8:    m = is_cos ? 32'(TWO_P32 / 33'd240) : 32'(TWO_P32 / 33'd272);
            4'd9:    m = is_cos ? 32'(TWO_P32 / 33'd306) : 32'(TWO_P32 / 33'd342);
            default: m = 32'd0;
        endcase
        return m;
    endfunction

endpackage

// File: rtl/core/lkw_if.sv
// Valid/ready channel interfaces for the kernel generator ports.
// No dependencies.
interface lkw_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] scale_ratio;
    modport source (output valid, output scale_ratio, input ready);
    modport sink   (input valid, input scale_ratio, output ready);
endinterface

interface lkw_out_if;
    logic               valid;
    logic               ready;
    logic [3:0]         tap_index;
    logic signed [15:0] tap_weight;
    logic [3:0]         tap_count;
    logic               last_tap;
    modport source (output valid, output tap_index, output tap_weight, output tap_count,
                    output last_tap, input ready);
    modport sink   (input valid, input tap_index, input tap_weight, input tap_count,
                    input last_tap, output ready);
endinterface

// File: rtl/core/lanczos_kernel_weights.sv
// Lanczos-2 kernel weight generator: one scale_ratio request (Q8.8) yields tap_count
// results, taps 0 up, each a Q2.14 weight normalized over the two-sided kernel. A
// two-entry queue lets new ratios be taken while a kernel is computed. For each kernel the
// job is taken, then the center tap and each tap outside the kernel support are set
// directly, and each side tap inside it gets a position divide on the shared 40-step
// radix-2 divider, eighteen series steps by reciprocal multiply and the final products;
// then each emitted tap is normalized by a divide on that divider; output stalls can hold it.
module lanczos_kernel_weights #(
    parameter int MAX_SAMPLES = 29
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lkw_in_if.sink    i_in,
    lkw_out_if.source o_out
);
    import lkw_pkg::*;

    logic fr_valid, fr_ready, bk_valid, bk_ready;
    t_job fr_job, bk_job;

    lkw_front #(.MAX_SAMPLES(MAX_SAMPLES)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(i_in),
        .o_job_valid(fr_valid), .o_job(fr_job), .i_job_ready(fr_ready)
    );

    lkw_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push_valid(fr_valid), .i_push_data(fr_job), .o_push_ready(fr_ready),
        .o_pop_valid(bk_valid), .o_pop_data(bk_job), .i_pop_ready(bk_ready)
    );

    lkw_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_job_valid(bk_valid), .i_job(bk_job), .o_job_ready(bk_ready), .o_out(o_out)
    );
endmodule

// File: rtl/core/lkw_front.sv
// Front end: accepts a ratio request, fixes zero ratio and works out the tap count.
// Depends on lkw_pkg and lkw_if.
module lkw_front #(
    parameter int MAX_SAMPLES = 29
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    lkw_in_if.sink        i_in,
    output logic          o_job_valid,
    output lkw_pkg::t_job o_job,
    input  logic          i_job_ready
);
    import lkw_pkg::*;

    logic        r_valid;
    t_job        r_job;
    logic [15:0] ratio;
    logic [9:0]  ceil2;
    logic [10:0] samples;
    logic [5:0]  taps;
    logic [17:0] dbl;

    always_comb begin
        ratio = (i_in.scale_ratio == 16'd0) ? 16'd1 : i_in.scale_ratio;
        dbl   = {1'b0, ratio, 1'b0} + 18'd255;
        ceil2 = dbl[17:8];
        samples = {ceil2, 1'b0} - 11'd1;
        if (samples > 11'(MAX_SAMPLES)) samples = 11'(MAX_SAMPLES);
        if (samples < 11'd3) samples = 11'd3;
        taps = 6'(samples[10:1]) + 6'd1;
        if (taps > 6'(TAP_SLOTS)) taps = 6'(TAP_SLOTS);
    end

    assign i_in.ready  = !r_valid || i_job_ready;
    assign o_job_valid = r_valid;
    assign o_job       = r_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
        if (i_in.valid && i_in.ready) begin
            r_job.ratio <= ratio;
            r_job.taps  <= taps[3:0];
        end
    end
endmodule

// File: rtl/core/lkw_queue.sv
// Two-entry request queue between front and back.
// Depends on lkw_pkg.
module lkw_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push_valid,
    input  lkw_pkg::t_job i_push_data,
    output logic          o_push_ready,
    output logic          o_pop_valid,
    output lkw_pkg::t_job o_pop_data,
    input  logic          i_pop_ready
);
    import lkw_pkg::*;

    t_job       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       push;
    logic       pop;

    assign o_push_ready = (r_cnt != 2'd2);
    assign o_pop_valid  = (r_cnt != 2'd0);
    assign o_pop_data   = r_mem[r_rp];
    assign push = i_push_valid && o_push_ready;
    assign pop  = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= !r_wp;
            if (pop)  r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
        if (push) r_mem[r_wp] <= i_push_data;
    end
endmodule

// File: rtl/core/lkw_div.sv
// Shared radix-2 restoring divider, 40-bit dividend by 24-bit divisor.
// Depends on lkw_pkg.
module lkw_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lkw_pkg::t_div_req i_req,
    output lkw_pkg::t_div_rsp o_rsp
);
    import lkw_pkg::*;

    logic        r_busy;
    logic        r_done;
    logic [5:0]  r_cnt;
    logic [23:0] r_rem;
    logic [39:0] r_quo;
    logic [23:0] r_dvs;
    logic [24:0] trial;
    logic        fit;

    assign trial = {r_rem, r_quo[39]};
    assign fit   = trial >= {1'b0, r_dvs};
    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 6'd0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd39) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
        if (i_req.start) begin
            r_rem <= 24'd0;
            r_quo <= i_req.dividend;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= fit ? 24'(trial - {1'b0, r_dvs}) : trial[23:0];
            r_quo <= {r_quo[38:0], fit};
        end
    end
endmodule

// File: rtl/core/lkw_back.sv
// Back end: raw Lanczos-2 weights by series evaluation, then normalization and output.
// Depends on lkw_pkg, lkw_if and lkw_div.
module lkw_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_job_valid,
    input  lkw_pkg::t_job i_job,
    output logic          o_job_ready,
    lkw_out_if.source     o_out
);
    import lkw_pkg::*;

    t_back_state r_state, n_state;
    t_job        r_job, n_job;
    logic [3:0]  r_tap, n_tap;
    logic [27:0] r_t, n_t;
    logic [27:0] r_t2, n_t2;
    logic [31:0] r_u, n_u;
    logic signed [33:0] r_acc, n_acc;
    logic signed [33:0] r_s, n_s;
    logic [3:0]  r_k, n_k;
    logic        r_cos, n_cos;
    logic signed [66:0] r_p, n_p;
    logic        r_neg, n_neg;
    logic [31:0] r_hx, n_hx;
    logic [31:0] r_hq, n_hq;
    logic signed [34:0] r_ss, n_ss;
    logic signed [68:0] r_lp, n_lp;
    logic signed [23:0] r_sum, n_sum;
    logic signed [15:0] r_w, n_w;
    logic signed [17:0] r_raw [TAP_SLOTS];
    logic        raw_we;
    logic signed [17:0] raw_wd;

    logic               r_ovalid, n_ovalid;
    logic [3:0]         r_oidx, n_oidx;
    logic signed [15:0] r_ow, n_ow;
    logic [3:0]         r_ocnt, n_ocnt;
    logic               r_olast, n_olast;

    t_div_req div_req;
    t_div_rsp div_rsp;

    lkw_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(div_req), .o_rsp(div_rsp));

    logic [55:0]        tt;
    logic [59:0]        tu;
    logic [66:0]        pmag;
    logic [63:0]        hprod;
    logic [8:0]         hd;
    logic [31:0]        hrem;
    logic [31:0]        hq;
    logic signed [33:0] sq;
    logic signed [33:0] acc_new;
    logic signed [67:0] s2;
    logic signed [68:0] lrnd;
    logic signed [17:0] rawc;
    logic [17:0]        rmag;
    logic               out_free;

    assign o_out.valid      = r_ovalid;
    assign o_out.tap_index  = r_oidx;
    assign o_out.tap_weight = r_ow;
    assign o_out.tap_count  = r_ocnt;
    assign o_out.last_tap   = r_olast;
    assign out_free = !r_ovalid || o_out.ready;

    always_comb begin
        n_state = r_state; n_job = r_job; n_tap = r_tap; n_t = r_t; n_t2 = r_t2;
        n_u = r_u; n_acc = r_acc; n_s = r_s; n_k = r_k; n_cos = r_cos; n_p = r_p;
        n_neg = r_neg; n_hx = r_hx; n_hq = r_hq;
        n_ss = r_ss; n_lp = r_lp; n_sum = r_sum; n_w = r_w;
        n_ovalid = r_ovalid && !o_out.ready;
        n_oidx = r_oidx; n_ow = r_ow; n_ocnt = r_ocnt; n_olast = r_olast;
        raw_we = 1'b0; raw_wd = 18'sd0;
        div_req = '0;
        o_job_ready = 1'b0;

        tt      = 56'(r_t) * 56'(r_t);
        tu      = 60'(r_t2) * 60'(PI2_Q28);
        pmag    = r_p[66] ? 67'(-r_p) : 67'(r_p);
        // series term divide: reciprocal estimate, then one compare-and-correct
        hprod   = {32'd0, r_hx} * {32'd0, horner_recip(r_k, r_cos)};
        hd      = horner_div(r_k, r_cos);
        hrem    = r_hx - r_hq * {23'd0, hd};
        hq      = (hrem >= {23'd0, hd}) ? r_hq + 32'd1 : r_hq;
        sq      = r_neg ? -$signed({2'b00, hq}) : $signed({2'b00, hq});
        acc_new = $signed({2'b00, ONE_Q28}) - sq;
        s2      = r_s * r_s;
        lrnd    = r_lp + (r_lp[68] ? 69'sh0_FFFF_FFFF_FF : 69'sd0);
        rawc    = lrnd[57:40];
        rmag    = r_raw[r_tap][17] ? 18'(-r_raw[r_tap]) : 18'(r_raw[r_tap]);

        unique case (r_state)
            B_IDLE: begin
                o_job_ready = 1'b1;
                if (i_job_valid) begin
                    n_job = i_job; n_tap = 4'd0; n_sum = 24'sd0; n_state = B_TAP;
                end
            end
            B_TAP: begin
                if (r_tap == 4'd0) begin
                    raw_we = 1'b1; raw_wd = $signed(CENTER_RAW);
                    n_sum = $signed({6'd0, CENTER_RAW});
                    n_state = B_NEXT;
                end else if ({5'd0, r_tap, 7'd0} >= r_job.ratio) begin
                    // beyond kernel support
                    raw_we = 1'b1; raw_wd = 18'sd0; n_state = B_NEXT;
                end else begin
                    div_req.start = 1'b1;
                    div_req.dividend = {1'b0, r_tap, 35'd0};
                    div_req.divisor = {8'd0, r_job.ratio};
                    n_state = B_TDIV;
                end
            end
            B_TDIV: if (div_rsp.done) begin
                n_t = div_rsp.quotient[27:0]; n_state = B_SQ;
            end
            B_SQ: begin n_t2 = tt[55:28]; n_state = B_U; end
            B_U: begin
                n_u = tu[59:28]; n_acc = $signed({2'b00, ONE_Q28});
                n_k = 4'(TERMS); n_cos = 1'b0; n_state = B_HMUL;
            end
            B_HMUL: begin n_p = $signed({1'b0, r_u}) * r_acc; n_state = B_HSTART; end
            B_HSTART: begin
                // |u*acc| stays below pi^2 in Q56, so the scaled term fits 32 bits
                n_hx = pmag[59:28];
                n_neg = r_p[66];
                n_state = B_HWAIT;
            end
            B_HWAIT: begin n_hq = hprod[63:32]; n_state = B_HFIX; end
            B_HFIX: begin
                if (r_k != 4'd1) begin
                    n_acc = acc_new; n_k = r_k - 4'd1; n_state = B_HMUL;
                end else if (!r_cos) begin
                    n_s = acc_new; n_acc = $signed({2'b00, ONE_Q28});
                    n_k = 4'(TERMS); n_cos = 1'b1; n_state = B_HMUL;
                end else begin
                    n_acc = acc_new; n_state = B_L1;
                end
            end
            B_L1: begin n_ss = $signed({1'b0, s2[61:28]}); n_state = B_L2; end
            B_L2: begin n_lp = r_ss * r_acc; n_state = B_L3; end
            B_L3: begin
                raw_we = 1'b1; raw_wd = rawc;
                n_sum = r_sum + 24'(rawc) + 24'(rawc);
                n_state = B_NEXT;
            end
            B_NEXT: begin
                if (r_tap == r_job.taps - 4'd1) begin
                    n_tap = 4'd0; n_state = B_NSTART;
                end else begin
                    n_tap = r_tap + 4'd1; n_state = B_TAP;
                end
            end
            B_NSTART: begin
                if (r_sum <= 24'sd0) begin
                    n_w = 16'sd0; n_state = B_NPUT;
                end else begin
                    div_req.start = 1'b1;
                    div_req.dividend = {8'd0, rmag, 14'd0};
                    div_req.divisor = r_sum;
                    n_state = B_NWAIT;
                end
            end
            B_NWAIT: if (div_rsp.done) begin
                if (!r_raw[r_tap][17])
                    n_w = (div_rsp.quotient > 40'd32767) ? 16'sh7FFF
                                                         : $signed(div_rsp.quotient[15:0]);
                else
                    n_w = (div_rsp.quotient > 40'd32768) ? 16'sh8000
                                                         : -$signed(div_rsp.quotient[15:0]);
                n_state = B_NPUT;
            end
            B_NPUT: if (out_free) begin
                n_ovalid = 1'b1; n_oidx = r_tap; n_ow = r_w; n_ocnt = r_job.taps;
                n_olast = (r_tap == r_job.taps - 4'd1);
                if (r_tap == r_job.taps - 4'd1) begin
                    n_state = B_IDLE;
                end else begin
                    n_tap = r_tap + 4'd1; n_state = B_NSTART;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_ovalid <= 1'b0;
            r_sum    <= 24'sd0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            r_sum    <= n_sum;
        end
        r_job <= n_job; r_tap <= n_tap; r_t <= n_t; r_t2 <= n_t2; r_u <= n_u;
        r_acc <= n_acc; r_s <= n_s; r_k <= n_k; r_cos <= n_cos; r_p <= n_p;
        r_neg <= n_neg; r_hx <= n_hx; r_hq <= n_hq;
        r_ss <= n_ss; r_lp <= n_lp; r_w <= n_w;
        r_oidx <= n_oidx; r_ow <= n_ow; r_ocnt <= n_ocnt; r_olast <= n_olast;
        if (raw_we) r_raw[r_tap] <= raw_wd;
    end
endmodule

// File: tb/sv/tb_lanczos_kernel_weights.sv
`timescale 1ns / 100ps
// Self-checking testbench for lanczos_kernel_weights: drives scale ratios, predicts every tap.
// Depends on lkw_pkg, lkw_if.sv (lkw_in_if, lkw_out_if) and the RTL top.
module tb_lanczos_kernel_weights;
    import lkw_pkg::*;

    localparam int        MAX_SAMPLES  = 29;
    localparam longint    Q28          = 64'sd1 << 28;
    localparam longint    PI_SQ_Q28    = 64'sd2649351758;
    localparam int        SERIES_TERMS = 9;
    localparam int        TAIL_CYCLES  = 400;
    localparam longint    CYCLE_LIMIT  = 10_000_000;

    typedef struct {
        logic [3:0]         idx;
        logic signed [15:0] weight;
        logic [3:0]         count;
        logic               last;
    } t_tap;

    logic   i_clk = 1'b0;
    logic   i_rst_n = 1'b0;
    t_tap   expected_taps[$];
    int     errors = 0;
    longint cycle_cnt = 0;
    bit     idle_on = 1'b1;
    int     stall_cnt = 0;

    lkw_in_if  in_if();
    lkw_out_if out_if();

    lanczos_kernel_weights #(.MAX_SAMPLES(MAX_SAMPLES)) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if.sink),
        .o_out  (out_if.source)
    );

    always #4 i_clk = ~i_clk;

    // ---------------- predictor ----------------
    function automatic longint series_eval(input longint u, input bit is_cos);
        longint acc;
        longint den;
        acc = Q28;
        for (int k = SERIES_TERMS; k >= 1; k--) begin
            den = is_cos ? longint'((2 * k - 1) * (2 * k)) : longint'((2 * k) * (2 * k + 1));
            acc = Q28 - (u * acc) / (Q28 * den);
        end
        return acc;
    endfunction

    function automatic int lanczos_raw(input int idx, input longint ratio);
        longint t, t2, u, s, c, l;
        if (idx == 0) return 65536;
        t = (longint'(idx) <<< 35) / ratio;
        if (t >= Q28) return 0;
        t2 = (t * t) >>> 28;
        u  = (t2 * PI_SQ_Q28) / Q28;
        s  = series_eval(u, 1'b0);
        c  = series_eval(u, 1'b1);
        l  = ((s * s) / Q28) * c / Q28;
        return int'(l / 4096);
    endfunction

    function automatic void predict_kernel(input logic [15:0] ratio_in);
        longint ratio, samples, q;
        int     taps;
        int     raw[TAP_SLOTS];
        int     sum;
        longint acc;
        t_tap   tap;
        ratio = (ratio_in == 16'd0) ? 1 : longint'(ratio_in);
        samples = ((2 * ratio + 255) >>> 8) * 2 - 1;
        if (samples > MAX_SAMPLES) samples = MAX_SAMPLES;
        if (samples < 3) samples = 3;
        taps = int'(samples / 2 + 1);
        if (taps > TAP_SLOTS) taps = TAP_SLOTS;
        acc = 0;
        for (int i = 0; i < taps; i++) begin
            raw[i] = lanczos_raw(i, ratio);
            acc += (i > 0) ? 2 * longint'(raw[i]) : longint'(raw[i]);
        end
        sum = int'(acc);
        for (int i = 0; i < taps; i++) begin
            q = 0;
            if (sum > 0) begin
                q = (longint'(raw[i]) * 16384) / longint'(sum);
                if (q > 32767) q = 32767;
                if (q < -32768) q = -32768;
            end
            tap.idx    = 4'(i);
            tap.weight = 16'(q);
            tap.count  = 4'(taps);
            tap.last   = (i + 1 == taps);
            expected_taps.push_back(tap);
        end
    endfunction

    // ---------------- request driver ----------------
    task automatic send_ratio(input logic [15:0] ratio);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        in_if.valid       <= 1'b1;
        in_if.scale_ratio <= ratio;
        do @(posedge i_clk); while (!in_if.ready);
        predict_kernel(ratio);
    endtask

    task automatic wait_all_taps();
        in_if.valid <= 1'b0;
        while (expected_taps.size() != 0) @(posedge i_clk);
    endtask

    // mostly cheap kernels, a few wide ones
    function automatic logic [15:0] pick_ratio();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 70) return 16'($urandom_range(0, 512));
        if (sel < 95) return 16'($urandom_range(513, 1024));
        return 16'($urandom);
    endfunction

    // ---------------- result checker ----------------
    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (expected_taps.size() == 0) begin
                $display("%0t: unexpected tap idx=%0d weight=%0d count=%0d last=%0b", $time,
                         out_if.tap_index, out_if.tap_weight, out_if.tap_count, out_if.last_tap);
                errors++;
            end else begin
                t_tap exp_tap;
                exp_tap = expected_taps.pop_front();
                if (out_if.tap_index !== exp_tap.idx) begin
                    $display("%0t: tap_index expected %0d actual %0d", $time,
                             exp_tap.idx, out_if.tap_index);
                    errors++;
                end
                if (out_if.tap_weight !== exp_tap.weight) begin
                    $display("%0t: tap_weight (tap %0d) expected %0d actual %0d", $time,
                             exp_tap.idx, exp_tap.weight, out_if.tap_weight);
                    errors++;
                end
                if (out_if.tap_count !== exp_tap.count) begin
                    $display("%0t: tap_count expected %0d actual %0d", $time,
                             exp_tap.count, out_if.tap_count);
                    errors++;
                end
                if (out_if.last_tap !== exp_tap.last) begin
                    $display("%0t: last_tap (tap %0d) expected %0b actual %0b", $time,
                             exp_tap.idx, exp_tap.last, out_if.last_tap);
                    errors++;
                end
            end
        end
    end

    // output back-pressure in bursts
    always @(posedge i_clk) begin
        if (stall_cnt > 0) begin
            stall_cnt--;
            out_if.ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_cnt = $urandom_range(0, 9);
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // ---------------- tests ----------------
    task automatic test_directed();
        logic [15:0] ratios[$];
        // zero ratio, narrowest kernels, tap count steps, saturated tap count, bit patterns
        ratios = '{16'd0, 16'd1, 16'd127, 16'd128, 16'd129, 16'd256, 16'd257, 16'd384,
                   16'd512, 16'd640, 16'd768, 16'd1024, 16'd1792, 16'd1793, 16'd3584,
                   16'd3585, 16'h5555, 16'hAAAA, 16'h8000, 16'hFFFF, 16'h00FF, 16'h0100};
        foreach (ratios[i]) send_ratio(ratios[i]);
        wait_all_taps();
    endtask

    task automatic test_random(input int n);
        for (int i = 0; i < n; i++) send_ratio(pick_ratio());
    endtask

    task automatic test_drained_pause();
        // sender holds off until every pending tap has come out
        wait_all_taps();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        for (int i = 0; i < 10; i++) send_ratio(pick_ratio());
        wait_all_taps();
    endtask

    task automatic test_streaming(input int n);
        idle_on = 1'b0;
        for (int i = 0; i < n; i++) send_ratio(pick_ratio());
        wait_all_taps();
    endtask

    initial begin
        in_if.valid       <= 1'b0;
        in_if.scale_ratio <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random(220);
        test_drained_pause();
        test_random(150);
        test_streaming(60);

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (errors == 0 && expected_taps.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
